FILE: rtl/obb_pkg.sv
// Shared types and widths for the oriented box overlap test.
// No dependencies.
`timescale 1ns / 1ps
package obb_pkg;
    localparam int FieldWidth = 48;
    typedef logic [FieldWidth-1:0] field_t;
    typedef struct packed {
        field_t box_a_center;
        field_t box_a_half_size;
        field_t box_a_row_x;
        field_t box_a_row_y;
        field_t box_a_row_z;
        logic   box_a_oriented;
        field_t box_b_center;
        field_t box_b_half_size;
        field_t box_b_row_x;
        field_t box_b_row_y;
        field_t box_b_row_z;
        logic   box_b_oriented;
    } obb_in_t;
endpackage

FILE: rtl/obb_if.sv
// Valid/ready channel carrying a payload of a given type.
// No dependencies; the payload type is a parameter.
`timescale 1ns / 1ps
interface obb_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/obb_obb_overlap_test.sv
// Oriented box pair overlap test, top level.
// Depends on obb_pkg and obb_if.
`timescale 1ns / 1ps
// One box pair enters per cycle unless the output stalls; its overlap flag leaves from the last stage.
// The pipeline has six register stages: unpack/difference, relative rotation
// products, rotation sums and absolute values, axis product terms, axis sums,
// and the final compare/reduce. A stall on the output holds every stage; the
// input is ready whenever the output stage is free or advancing.
module obb_obb_overlap_test #(
    parameter int COORD_WIDTH     = 16,
    parameter int BASIS_FRAC_BITS = 14
) (
    input logic clk,
    input logic rst_n,
    obb_if.sink   in_ch,
    obb_if.source out_ch
);
    import obb_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int F  = BASIS_FRAC_BITS;
    localparam int DW = CW + 1;             // center difference
    localparam int RW = 2*CW + 2;           // rotation entry sum
    localparam int CCW = CW + DW + 2;       // rotated offset
    localparam int WW = 128;
    localparam int NS = 6;

    // pipeline control
    logic [NS-1:0] vld_reg;
    logic adv;
    assign adv = !vld_reg[NS-1] || out_ch.ready;
    assign in_ch.ready = adv;
    assign out_ch.valid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NS-2:0], in_ch.valid};
    end

    function automatic logic signed [CW-1:0] fs(field_t v, int i);
        return v[i*CW +: CW];
    endfunction

    // stage 1: basis, extents, difference
    logic signed [CW-1:0] ma_reg [3][3], mb_reg [3][3];
    logic [CW-1:0] a1_reg [3], b1_reg [3];
    logic signed [DW-1:0] d_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    field_t ra, rb;
                    ra = (i == 0) ? in_ch.data.box_a_row_x :
                         (i == 1) ? in_ch.data.box_a_row_y : in_ch.data.box_a_row_z;
                    rb = (i == 0) ? in_ch.data.box_b_row_x :
                         (i == 1) ? in_ch.data.box_b_row_y : in_ch.data.box_b_row_z;
                    ma_reg[i][j] <= in_ch.data.box_a_oriented ? fs(ra, j) :
                        ((i == j) ? CW'(64'sd1 <<< F) : '0);
                    mb_reg[i][j] <= in_ch.data.box_b_oriented ? fs(rb, j) :
                        ((i == j) ? CW'(64'sd1 <<< F) : '0);
                end
                a1_reg[i] <= in_ch.data.box_a_half_size[i*CW +: CW];
                b1_reg[i] <= in_ch.data.box_b_half_size[i*CW +: CW];
                d_reg[i] <= DW'(fs(in_ch.data.box_b_center, i))
                          - DW'(fs(in_ch.data.box_a_center, i));
            end
        end
    end

    // stage 2: products for R and c
    logic signed [2*CW-1:0] rp_reg [3][3][3];
    logic signed [CW+DW-1:0] cp_reg [3][3];
    logic [CW-1:0] a2_reg [3], b2_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    cp_reg[i][k] <= ma_reg[i][k] * d_reg[k];
                    for (int j = 0; j < 3; j++)
                        rp_reg[i][j][k] <= ma_reg[i][k] * mb_reg[j][k];
                end
                a2_reg[i] <= a1_reg[i];
                b2_reg[i] <= b1_reg[i];
            end
        end
    end

    // stage 3: sums and absolute values
    logic signed [RW-1:0] r_reg [3][3];
    logic [RW-1:0] ra_reg [3][3];
    logic signed [CCW-1:0] c_reg [3];
    logic [CW-1:0] a3_reg [3], b3_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                c_reg[i] <= CCW'(cp_reg[i][0]) + CCW'(cp_reg[i][1]) + CCW'(cp_reg[i][2]);
                for (int j = 0; j < 3; j++)
                begin
                    logic signed [RW-1:0] s;
                    s = RW'(rp_reg[i][j][0]) + RW'(rp_reg[i][j][1]) + RW'(rp_reg[i][j][2]);
                    r_reg[i][j] <= s;
                    ra_reg[i][j] <= s[RW-1] ? -s : s;
                end
                a3_reg[i] <= a2_reg[i];
                b3_reg[i] <= b2_reg[i];
            end
        end
    end

    // stage 4: product terms (unsigned products of extents and |R|, signed products of c and R)
    localparam int PW = CW + RW + 1;
    localparam int QW = CCW + RW;
    logic signed [PW-1:0] pa_reg [3][3], pb_reg [3][3];
    logic signed [PW-1:0] pt_reg [3][3], pu_reg [3][3];
    logic signed [QW-1:0] pc_reg [3][3];
    logic signed [WW-1:0] asum7_reg;
    logic signed [CCW-1:0] c4_reg [3];
    logic [CW-1:0] a4_reg [3], b4_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    pa_reg[i][j] <= $signed({1'b0, a3_reg[i]}) * $signed({1'b0, ra_reg[i][j]});
                    pb_reg[i][j] <= $signed({1'b0, b3_reg[j]}) * $signed({1'b0, ra_reg[i][j]});
                    pc_reg[i][j] <= c_reg[i] * r_reg[i][j];
                    // extent terms of the edge cross axes
                    pt_reg[i][j] <=
                        $signed({1'b0, a3_reg[(i+1)%3]}) * $signed({1'b0, ra_reg[(i+2)%3][j]})
                      + $signed({1'b0, a3_reg[(i+2)%3]}) * $signed({1'b0, ra_reg[(i+1)%3][j]});
                    pu_reg[i][j] <=
                        $signed({1'b0, b3_reg[(j+1)%3]}) * $signed({1'b0, ra_reg[i][(j+2)%3]})
                      + $signed({1'b0, b3_reg[(j+2)%3]}) * $signed({1'b0, ra_reg[i][(j+1)%3]});
                end
                c4_reg[i] <= c_reg[i];
                a4_reg[i] <= a3_reg[i];
                b4_reg[i] <= b3_reg[i];
            end
            asum7_reg <= (WW'(a3_reg[0]) + WW'(a3_reg[1]) + WW'(a3_reg[2])) * 7;
        end
    end
    logic signed [QW-1:0] px_reg [3][3][3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    for (int k = 0; k < 3; k++)
                        px_reg[i][j][k] <= c_reg[k] * r_reg[i][j];
        end
    end

    // stage 5: per-axis sides at full width
    logic signed [WW-1:0] lhs_reg [15], rhs_reg [15];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic signed [WW-1:0] l, r;
                l = WW'(c4_reg[i]);
                l = (l < 0) ? -l : l;
                r = WW'(a4_reg[i]) <<< (2*F);
                for (int j = 0; j < 3; j++)
                    r = r + WW'(pb_reg[i][j]);
                lhs_reg[i] <= l <<< F;
                rhs_reg[i] <= r;
            end
            for (int j = 0; j < 3; j++)
            begin
                logic signed [WW-1:0] p, bd;
                p = '0;
                bd = '0;
                for (int i = 0; i < 3; i++)
                begin
                    p = p + WW'(pc_reg[i][j]);
                    bd = bd + WW'(pa_reg[i][j]);
                end
                lhs_reg[3+j] <= (p < 0) ? -p : p;
                rhs_reg[3+j] <= (bd <<< F) + (WW'(b4_reg[j]) <<< (3*F));
            end
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    logic signed [WW-1:0] t1, t2, t3;
                    t1 = WW'(pt_reg[i][j]);
                    t2 = WW'(pu_reg[i][j]);
                    t3 = WW'(px_reg[(i+1)%3][j][(i+2)%3]) - WW'(px_reg[(i+2)%3][j][(i+1)%3]);
                    lhs_reg[6+3*i+j] <= ((t3 < 0) ? -t3 : t3) <<< 16;
                    rhs_reg[6+3*i+j] <= ((t1 + t2) <<< (F + 16)) + (asum7_reg <<< (3*F));
                end
            end
        end
    end

    // stage 6: compare and reduce
    logic ovl_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic sep;
            sep = 1'b0;
            for (int k = 0; k < 15; k++)
                sep = sep | (lhs_reg[k] > rhs_reg[k]);
            ovl_reg <= !sep;
        end
    end
    assign out_ch.data = ovl_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("result dropped during stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("input blocked with empty output");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> vld_reg[0])
        else $error("accepted item not tracked");
endmodule

FILE: test/tb_overlap_checker.sv
// Checker for the oriented box overlap test: watches both channels, predicts
// the overlap flag of each accepted box pair and compares it in order.
// Depends on obb_pkg.
`timescale 1ns / 1ps
module tb_overlap_checker #(
    parameter int COORD_WIDTH     = 16,
    parameter int BASIS_FRAC_BITS = 14
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pair_valid,
    input  logic             pair_ready,
    input  obb_pkg::obb_in_t pair_data,
    input  logic             flag_valid,
    input  logic             flag_ready,
    input  logic             flag_data,
    output int               mismatches,
    output int               pending
);
    import obb_pkg::*;

    typedef logic signed [127:0] wide_t;

    bit flag_queue[$];

    function automatic longint comp_signed(field_t v, int idx);
        logic [COORD_WIDTH-1:0] raw;
        raw = v[idx*COORD_WIDTH +: COORD_WIDTH];
        return longint'($signed(raw));
    endfunction

    function automatic longint comp_unsigned(field_t v, int idx);
        logic [COORD_WIDTH-1:0] raw;
        raw = v[idx*COORD_WIDTH +: COORD_WIDTH];
        return longint'({1'b0, raw});
    endfunction

    function automatic wide_t wabs(wide_t v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic bit predict_overlap(obb_in_t p);
        longint ma[3][3], mb[3][3], rot[3][3], rabs[3][3];
        longint ha[3], hb[3], delta[3], off[3];
        longint hsum;
        wide_t lhs, rhs, t1, t2, t3;
        int i1, i2, j1, j2;
        bit split;
        field_t rows_a[3], rows_b[3];
        rows_a = '{p.box_a_row_x, p.box_a_row_y, p.box_a_row_z};
        rows_b = '{p.box_b_row_x, p.box_b_row_y, p.box_b_row_z};
        split = 0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                ma[i][j] = p.box_a_oriented ? comp_signed(rows_a[i], j)
                         : ((i == j) ? (longint'(1) << BASIS_FRAC_BITS) : 0);
                mb[i][j] = p.box_b_oriented ? comp_signed(rows_b[i], j)
                         : ((i == j) ? (longint'(1) << BASIS_FRAC_BITS) : 0);
            end
            ha[i] = comp_unsigned(p.box_a_half_size, i);
            hb[i] = comp_unsigned(p.box_b_half_size, i);
            delta[i] = comp_signed(p.box_b_center, i) - comp_signed(p.box_a_center, i);
        end
        for (int i = 0; i < 3; i++)
        begin
            off[i] = 0;
            for (int k = 0; k < 3; k++)
                off[i] += ma[i][k] * delta[k];
            for (int j = 0; j < 3; j++)
            begin
                rot[i][j] = 0;
                for (int k = 0; k < 3; k++)
                    rot[i][j] += ma[i][k] * mb[j][k];
                rabs[i][j] = (rot[i][j] < 0) ? -rot[i][j] : rot[i][j];
            end
        end
        hsum = ha[0] + ha[1] + ha[2];

        // faces of the first box
        for (int i = 0; i < 3; i++)
        begin
            lhs = wabs(wide_t'(off[i])) <<< BASIS_FRAC_BITS;
            rhs = wide_t'(ha[i]) <<< (2 * BASIS_FRAC_BITS);
            for (int j = 0; j < 3; j++)
                rhs += wide_t'(hb[j]) * wide_t'(rabs[i][j]);
            if (lhs > rhs)
                split = 1;
        end
        // faces of the second box
        for (int j = 0; j < 3; j++)
        begin
            lhs = 0;
            rhs = 0;
            for (int i = 0; i < 3; i++)
            begin
                lhs += wide_t'(off[i]) * wide_t'(rot[i][j]);
                rhs += wide_t'(ha[i]) * wide_t'(rabs[i][j]);
            end
            rhs = (rhs <<< BASIS_FRAC_BITS) + (wide_t'(hb[j]) <<< (3 * BASIS_FRAC_BITS));
            if (wabs(lhs) > rhs)
                split = 1;
        end
        // edge cross axes, widened by the tolerance
        for (int i = 0; i < 3; i++)
        begin
            i1 = (i + 1) % 3;
            i2 = (i + 2) % 3;
            for (int j = 0; j < 3; j++)
            begin
                j1 = (j + 1) % 3;
                j2 = (j + 2) % 3;
                t1 = wide_t'(ha[i1]) * wide_t'(rabs[i2][j])
                   + wide_t'(ha[i2]) * wide_t'(rabs[i1][j]);
                t2 = wide_t'(hb[j1]) * wide_t'(rabs[i][j2])
                   + wide_t'(hb[j2]) * wide_t'(rabs[i][j1]);
                t3 = wide_t'(off[i2]) * wide_t'(rot[i1][j])
                   - wide_t'(off[i1]) * wide_t'(rot[i2][j]);
                lhs = wabs(t3) <<< 16;
                rhs = ((t1 + t2) <<< (BASIS_FRAC_BITS + 16))
                    + (wide_t'(hsum * 7) <<< (3 * BASIS_FRAC_BITS));
                if (lhs > rhs)
                    split = 1;
            end
        end
        return !split;
    endfunction

    assign pending = flag_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        bit want;
        if (!rst_n)
        begin
            flag_queue.delete();
            mismatches <= 0;
        end
        else
        begin
            if (pair_valid && pair_ready)
                flag_queue.push_back(predict_overlap(pair_data));
            if (flag_valid && flag_ready)
            begin
                if (flag_queue.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("[%0t] overlap flag %0b with none expected", $realtime,
                                 flag_data);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = flag_queue.pop_front();
                    if (flag_data !== want)
                    begin
                        if (mismatches < 10)
                            $display("[%0t] overlap mismatch: expected %0b, got %0b",
                                     $realtime, want, flag_data);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: test/tb_top.sv
// Top of the overlap test bench: clock, reset, box pair stimulus, output
// back-pressure, watchdog and verdict. Depends on obb_pkg, obb_if, the block
// and tb_overlap_checker.
`timescale 1ns / 1ps
module tb_top;
    import obb_pkg::*;

    localparam int WatchdogLimit = 20000;
    localparam int HoldOffCycles = 300;

    logic clk = 0;
    logic rst_n = 0;
    int   sender_idle_pct = 0;
    int   receiver_stall_pct = 0;
    bit   hold_off_req = 0;
    bit   hold_off_taken = 0;
    int   hold_off_left = 0;
    int   mismatches;
    int   pending;
    int   quiet_cycles = 0;

    obb_if #(.payload_t(obb_in_t)) pair_if ();
    obb_if #(.payload_t(logic))    flag_if ();

    obb_obb_overlap_test dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (pair_if.sink),
        .out_ch (flag_if.source)
    );

    tb_overlap_checker checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pair_if.valid),
        .pair_ready (pair_if.ready),
        .pair_data  (pair_if.data),
        .flag_valid (flag_if.valid),
        .flag_ready (flag_if.ready),
        .flag_data  (flag_if.data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_off_req && !hold_off_taken)
        begin
            hold_off_taken <= 1;
            hold_off_left <= HoldOffCycles;
            flag_if.ready <= 0;
        end
        else if (hold_off_left > 0)
        begin
            hold_off_left <= hold_off_left - 1;
            flag_if.ready <= 0;
        end
        else
            flag_if.ready <= rst_n && ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((pair_if.valid && pair_if.ready) || (flag_if.valid && flag_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WatchdogLimit)
        begin
            $display("FAIL obb_obb_overlap_test");
            $finish;
        end
    end

    function automatic field_t pack3(longint x, longint y, longint z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    function automatic field_t rand_field();
        return field_t'({$urandom(), $urandom()});
    endfunction

    // rotation rows: signed permutation, random entries from -16384 to 16384, or raw bits
    function automatic void rand_rows(output field_t rx, output field_t ry,
                                      output field_t rz);
        int perm[3];
        longint m[3][3];
        int sel;
        sel = $urandom_range(9);
        if (sel < 5)
        begin
            perm = '{0, 1, 2};
            perm.shuffle();
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    m[i][j] = (perm[i] == j) ? ($urandom_range(1) ? 16384 : -16384) : 0;
        end
        else if (sel < 8)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    m[i][j] = longint'($urandom_range(32768)) - 16384;
        end
        else
        begin
            rx = rand_field();
            ry = rand_field();
            rz = rand_field();
            return;
        end
        rx = pack3(m[0][0], m[0][1], m[0][2]);
        ry = pack3(m[1][0], m[1][1], m[1][2]);
        rz = pack3(m[2][0], m[2][1], m[2][2]);
    endfunction

    function automatic field_t rand_center();
        if ($urandom_range(9) == 0)
            return rand_field();
        return pack3(longint'($urandom_range(4000)) - 2000,
                     longint'($urandom_range(4000)) - 2000,
                     longint'($urandom_range(4000)) - 2000);
    endfunction

    function automatic field_t rand_half();
        if ($urandom_range(9) == 0)
            return rand_field();
        return pack3($urandom_range(1200), $urandom_range(1200), $urandom_range(1200));
    endfunction

    function automatic obb_in_t rand_pair();
        obb_in_t p;
        p.box_a_center = rand_center();
        p.box_a_half_size = rand_half();
        rand_rows(p.box_a_row_x, p.box_a_row_y, p.box_a_row_z);
        p.box_a_oriented = ($urandom_range(3) != 0);
        p.box_b_center = rand_center();
        p.box_b_half_size = rand_half();
        rand_rows(p.box_b_row_x, p.box_b_row_y, p.box_b_row_z);
        p.box_b_oriented = ($urandom_range(3) != 0);
        return p;
    endfunction

    task automatic send_pair(obb_in_t p);
        pair_if.valid <= 1;
        pair_if.data <= p;
        @(posedge clk);
        while (!pair_if.ready)
            @(posedge clk);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            pair_if.valid <= 0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
    endtask

    task automatic send_directed();
        obb_in_t p;
        field_t ident_x, ident_y, ident_z;
        ident_x = pack3(16384, 0, 0);
        ident_y = pack3(0, 16384, 0);
        ident_z = pack3(0, 0, 16384);
        p = '0;
        send_pair(p);
        // exact touching along x, then one step apart along x and along z
        p.box_a_half_size = pack3(64, 64, 64);
        p.box_b_half_size = pack3(64, 64, 64);
        p.box_b_center = pack3(128, 0, 0);
        send_pair(p);
        p.box_b_center = pack3(129, 0, 0);
        send_pair(p);
        p.box_b_center = pack3(0, 0, -129);
        send_pair(p);
        // oriented identity equals unoriented
        p.box_a_row_x = ident_x; p.box_a_row_y = ident_y; p.box_a_row_z = ident_z;
        p.box_b_row_x = ident_x; p.box_b_row_y = ident_y; p.box_b_row_z = ident_z;
        for (int k = 0; k < 4; k++)
        begin
            p.box_a_oriented = k[0];
            p.box_b_oriented = k[1];
            send_pair(p);
        end
        // 45 degree rotation of the second box about z, corner reaching across
        p.box_b_row_x = pack3(11585, 11585, 0);
        p.box_b_row_y = pack3(-11585, 11585, 0);
        p.box_b_center = pack3(150, 0, 0);
        send_pair(p);
        p.box_b_center = pack3(160, 160, 0);
        send_pair(p);
        // half-extents with top bit set are huge, not negative
        p.box_a_half_size = {48{1'b1}};
        p.box_b_center = pack3(32767, -32768, 32767);
        send_pair(p);
        p.box_a_half_size = pack3(32768, 32768, 32768);
        p.box_a_center = pack3(-32768, 32767, -32768);
        send_pair(p);
        // extreme rotation entries, non-orthonormal
        p.box_a_half_size = pack3(100, 200, 300);
        p.box_a_row_x = pack3(-32768, 32767, -32768);
        p.box_a_row_y = pack3(32767, 32767, 32767);
        p.box_a_row_z = pack3(-32768, -32768, -32768);
        p.box_a_oriented = 1;
        send_pair(p);
        p = '1;
        send_pair(p);
        p.box_a_oriented = 0;
        p.box_b_oriented = 0;
        send_pair(p);
        p = '0;
        p.box_a_center = pack3(32767, 32767, 32767);
        p.box_b_center = pack3(-32768, -32768, -32768);
        p.box_b_half_size = {48{1'b1}};
        send_pair(p);
        p.box_b_half_size = '0;
        send_pair(p);
    endtask

    initial
    begin
        int idle_set[4] = '{0, 80, 0, 35};
        int stall_set[4] = '{0, 0, 80, 35};
        int waited;
        pair_if.valid <= 0;
        pair_if.data <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        for (int ph = 0; ph < 4; ph++)
        begin
            sender_idle_pct = idle_set[ph];
            receiver_stall_pct = stall_set[ph];
            if (ph == 0)
                send_directed();
            if (ph == 1)
                hold_off_req <= 1;
            for (int n = 0; n < 345; n++)
            begin
                // quiet stretch without sender gaps every so often
                if (n % 100 == 50)
                    sender_idle_pct = 0;
                else if (n % 100 == 80)
                    sender_idle_pct = idle_set[ph];
                send_pair(rand_pair());
            end
        end
        pair_if.valid <= 0;
        waited = 0;
        while (pending != 0 && waited < WatchdogLimit)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS obb_obb_overlap_test");
        else
            $display("FAIL obb_obb_overlap_test");
        $finish;
    end
endmodule
